// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; take in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Check cons in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== sv/ica_pkg.sv =====
// Package for the integer calculator ALU: operation codes, sequencer states
// and fixed widths. Depends on nothing.
`default_nettype none

package ica_pkg;

   localparam int RESULT_WIDTH = 64;
   localparam int ROUND_GUARD = 8;
   localparam logic [3:0] DIGIT_RADIX = 4'd10;

   typedef enum logic [3:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_DIV     = 4'd3,
      OP_MOD     = 4'd4,
      OP_AND     = 4'd5,
      OP_OR      = 4'd6,
      OP_XOR     = 4'd7,
      OP_TO_BASE = 4'd8
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_EXACT,
      ST_DIV_ROUND,
      ST_MOD,
      ST_CONV_DIV,
      ST_CONV_MUL,
      ST_CONV_ACC,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== sv/ica_divider.sv =====
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Self-contained; used by the integer calculator ALU top level.
`default_nettype none

module ica_divider #(
   parameter int WIDTH = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CW = $clog2(WIDTH);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH+1:0] diff;

   assign trial = {rem_ff, quo_ff[WIDTH-1]};
   assign diff  = {1'b0, trial} - {2'b00, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CW'(WIDTH - 1);
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         if (!diff[WIDTH+1]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== sv/integer_calculator_alu_unit.sv =====
// Integer calculator ALU: top level with sequencer, multiplier and result register.
// Depends on ica_pkg and ica_divider.
//
// One transfer on req_ gives one transfer on rsp_; the block takes a new item
// only while its sequencer is idle, but a finished result may still wait in the
// output register. Add, subtract, and, or, xor and invalid items go from the
// idle state straight to the finish state; multiply passes through the MUL
// state first. Divide, modulo and every digit of a base conversion run through
// one bit-serial divider of OPERAND_WIDTH+8 bits, one quotient bit per cycle:
// modulo and whole divides run it once, an inexact divide runs it twice, and a
// conversion runs it once per output digit.
`default_nettype none

module integer_calculator_alu_unit #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   input  logic [3:0]         req_operation,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_result_value,
   output logic               rsp_scaled_by_100,
   output logic               rsp_invalid
);

   localparam int W  = OPERAND_WIDTH;
   localparam int RW = ica_pkg::RESULT_WIDTH;
   localparam int DW = OPERAND_WIDTH + ica_pkg::ROUND_GUARD;

   function automatic logic [RW-1:0] sext_w(input logic [W-1:0] x);
      return {{(RW-W){x[W-1]}}, x};
   endfunction

   ica_pkg::state_type state_ff, state_in;

   logic [W-1:0]  a_w, b_w, ua_c, ub_c;
   logic          a_neg, b_neg, b_zero, b_lt2;
   logic [RW-1:0] imm_res;
   logic          imm_bad;

   logic [W-1:0]  a_bits_ff, b_bits_ff, ua_ff, ub_ff;
   logic          a_neg_ff, sign_ff;
   logic [W-1:0]  cur_ff, digit_ff, prod_ff, acc_ff, place_ff;
   logic [W-1:0]  acc_sum, acc_fix;
   logic [RW-1:0] res_ff;
   logic          scaled_ff, bad_ff;

   logic          rsp_valid_ff;
   logic [RW-1:0] rsp_result_ff;
   logic          rsp_scaled_ff, rsp_invalid_ff;
   logic          rsp_load;

   logic [W-1:0]  mul_x, mul_y, mul_lo;

   logic          div_start, div_done;
   logic [DW-1:0] div_dividend, div_divisor, div_quo, div_rem;
   logic [DW-1:0] ua_x, round_num;

   assign a_w    = req_operand_a[W-1:0];
   assign b_w    = req_operand_b[W-1:0];
   assign a_neg  = a_w[W-1];
   assign b_neg  = b_w[W-1];
   assign ua_c   = a_neg ? -a_w : a_w;
   assign ub_c   = b_neg ? -b_w : b_w;
   assign b_zero = (b_w == '0);
   assign b_lt2  = b_neg || (b_w < W'(2));

   always_comb begin
      imm_res = '0;
      imm_bad = 1'b0;
      case (req_operation)
         ica_pkg::OP_ADD:     imm_res = sext_w(a_w + b_w);
         ica_pkg::OP_SUB:     imm_res = sext_w(a_w - b_w);
         ica_pkg::OP_AND:     imm_res = sext_w(a_w & b_w);
         ica_pkg::OP_OR:      imm_res = sext_w(a_w | b_w);
         ica_pkg::OP_XOR:     imm_res = sext_w(a_w ^ b_w);
         ica_pkg::OP_MUL:     imm_res = '0;
         ica_pkg::OP_DIV:     imm_bad = b_zero;
         ica_pkg::OP_MOD:     imm_bad = b_zero;
         ica_pkg::OP_TO_BASE: imm_bad = b_lt2;
         default:             imm_bad = 1'b1;
      endcase
   end

   assign mul_x  = (state_ff == ica_pkg::ST_CONV_MUL) ? digit_ff : a_bits_ff;
   assign mul_y  = (state_ff == ica_pkg::ST_CONV_MUL) ? place_ff : b_bits_ff;
   assign mul_lo = mul_x * mul_y;

   assign acc_sum = acc_ff + prod_ff;
   assign acc_fix = a_neg_ff ? -acc_sum : acc_sum;

   // a*200 + b over 2b rounds a*100/b half away from zero
   assign ua_x      = DW'(ua_ff);
   assign round_num = (ua_x << 7) + (ua_x << 6) + (ua_x << 3) + DW'(ub_ff);

   assign rsp_load = (state_ff == ica_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ica_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_operation)
                  ica_pkg::OP_MUL: state_in = ica_pkg::ST_MUL;
                  ica_pkg::OP_DIV:
                     state_in = b_zero ? ica_pkg::ST_FINISH : ica_pkg::ST_DIV_EXACT;
                  ica_pkg::OP_MOD:
                     state_in = b_zero ? ica_pkg::ST_FINISH : ica_pkg::ST_MOD;
                  ica_pkg::OP_TO_BASE:
                     state_in = (b_lt2 || ua_c == '0) ? ica_pkg::ST_FINISH
                                                      : ica_pkg::ST_CONV_DIV;
                  default: state_in = ica_pkg::ST_FINISH;
               endcase
            end
         end
         ica_pkg::ST_MUL: state_in = ica_pkg::ST_FINISH;
         ica_pkg::ST_DIV_EXACT: begin
            if (div_done) begin
               state_in = (div_rem == '0) ? ica_pkg::ST_FINISH : ica_pkg::ST_DIV_ROUND;
            end
         end
         ica_pkg::ST_DIV_ROUND: if (div_done) state_in = ica_pkg::ST_FINISH;
         ica_pkg::ST_MOD:       if (div_done) state_in = ica_pkg::ST_FINISH;
         ica_pkg::ST_CONV_DIV:  if (div_done) state_in = ica_pkg::ST_CONV_MUL;
         ica_pkg::ST_CONV_MUL:  state_in = ica_pkg::ST_CONV_ACC;
         ica_pkg::ST_CONV_ACC:
            state_in = (cur_ff == '0) ? ica_pkg::ST_FINISH : ica_pkg::ST_CONV_DIV;
         ica_pkg::ST_FINISH:    if (rsp_load) state_in = ica_pkg::ST_IDLE;
         default:               state_in = ica_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready    = 1'b0;
      div_start    = 1'b0;
      div_dividend = DW'(cur_ff);
      div_divisor  = DW'(ub_ff);
      case (state_ff)
         ica_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            div_dividend = DW'(ua_c);
            div_divisor  = DW'(ub_c);
            if (req_valid) begin
               case (req_operation)
                  ica_pkg::OP_DIV:     div_start = !b_zero;
                  ica_pkg::OP_MOD:     div_start = !b_zero;
                  ica_pkg::OP_TO_BASE: div_start = !b_lt2 && (ua_c != '0);
                  default:             div_start = 1'b0;
               endcase
            end
         end
         ica_pkg::ST_DIV_EXACT: begin
            div_dividend = round_num;
            div_divisor  = DW'({ub_ff, 1'b0});
            div_start    = div_done && (div_rem != '0);
         end
         ica_pkg::ST_CONV_ACC: div_start = (cur_ff != '0);
         default: div_start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ica_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      case (state_ff)
         ica_pkg::ST_IDLE: begin
            if (req_valid) begin
               a_bits_ff <= a_w;
               b_bits_ff <= b_w;
               ua_ff     <= ua_c;
               ub_ff     <= ub_c;
               a_neg_ff  <= a_neg;
               sign_ff   <= a_neg ^ b_neg;
               res_ff    <= imm_res;
               scaled_ff <= 1'b0;
               bad_ff    <= imm_bad;
               acc_ff    <= '0;
               place_ff  <= W'(1);
            end
         end
         ica_pkg::ST_MUL: res_ff <= sext_w(mul_lo);
         ica_pkg::ST_DIV_EXACT: begin
            if (div_done && div_rem == '0) begin
               res_ff <= sign_ff ? -RW'(div_quo[W-1:0]) : RW'(div_quo[W-1:0]);
            end
         end
         ica_pkg::ST_DIV_ROUND: begin
            if (div_done) begin
               res_ff    <= sign_ff ? -RW'(div_quo) : RW'(div_quo);
               scaled_ff <= 1'b1;
            end
         end
         ica_pkg::ST_MOD: begin
            if (div_done) begin
               res_ff <= a_neg_ff ? -RW'(div_rem[W-1:0]) : RW'(div_rem[W-1:0]);
            end
         end
         ica_pkg::ST_CONV_DIV: begin
            if (div_done) begin
               cur_ff   <= div_quo[W-1:0];
               digit_ff <= div_rem[W-1:0];
            end
         end
         ica_pkg::ST_CONV_MUL: prod_ff <= mul_lo;
         ica_pkg::ST_CONV_ACC: begin
            acc_ff   <= acc_sum;
            place_ff <= place_ff * ica_pkg::DIGIT_RADIX;
            res_ff   <= sext_w(acc_fix);
         end
         default: begin
         end
      endcase

      if (rsp_load) begin
         rsp_result_ff  <= res_ff;
         rsp_scaled_ff  <= scaled_ff;
         rsp_invalid_ff <= bad_ff;
      end
   end

   ica_divider #(
      .WIDTH(DW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_value  = rsp_result_ff;
   assign rsp_scaled_by_100 = rsp_scaled_ff;
   assign rsp_invalid       = rsp_invalid_ff;

endmodule

`default_nettype wire

// ===== sv/ica_checker.sv =====
// Port checker for the integer calculator ALU, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module ica_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [63:0] rsp_result_value,
   input wire logic               rsp_scaled_by_100,
   input wire logic               rsp_invalid
);

   logic [1:0] outstanding_ff, outstanding_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_xfer && !rsp_xfer) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (!req_xfer && rsp_xfer) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= 2'd0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `ASSERT_IMPLY(a_invalid_clean, clock, reset, rsp_valid && rsp_invalid, rsp_result_value == 64'sd0 && !rsp_scaled_by_100)
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_xfer, !req_ready)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value))
   `ASSERT_IMPLY(a_no_phantom_rsp, clock, reset, rsp_valid, outstanding_ff != 2'd0)
   `ASSERT_IMPLY(a_depth_bound, clock, reset, 1'b1, outstanding_ff != 2'd3)

endmodule

bind integer_calculator_alu_unit ica_checker u_ica_checker (.*);

`default_nettype wire
